// ----- rtl/sle_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sequence list engine.
// No dependencies; sle_ctrl, sle_dpath and the top level import this package.
package sle_pkg;

    localparam int DATA_W      = 16;
    localparam int CMD_W       = 4;
    localparam int IDX_W       = 7;
    localparam int POS_W       = 6;
    localparam int CNT_W       = 7;
    localparam int STS_W       = 2;
    localparam int MAX_RESULTS = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT = 4'd2;
    localparam logic [CMD_W-1:0] CMD_READ      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_FIND      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE_VAL = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DEDUPE    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_REVERSE   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SORT      = 4'd8;
    localparam logic [CMD_W-1:0] CMD_RUN       = 4'd9;
    localparam logic [CMD_W-1:0] CMD_PARTITION = 4'd10;

    // result status codes
    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_BAD_INDEX = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL      = 2'd2;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd3;

    typedef enum logic [5:0] {
        OP_NOP, OP_LOAD, OP_CLEAR,
        OP_INS_INIT, OP_INS_RD, OP_INS_WR, OP_INS_PUT,
        OP_RM_INIT, OP_RM_RD, OP_RM_WR, OP_RM_END,
        OP_SCAN_INIT, OP_RD_I, OP_RD_J,
        OP_FD_EV, OP_RV_EV, OP_SET_LEN_W,
        OP_DD_HOLD, OP_DD_ADD, OP_DD_JEV,
        OP_ST_HOLD, OP_ST_JEV, OP_ST_PUT,
        OP_PC_EV,
        OP_REV_INIT, OP_REV_INIT2, OP_REV_RA, OP_REV_RB, OP_REV_WA, OP_REV_WB,
        OP_RN_HOLD, OP_RN_EV, OP_RD_BST,
        OP_EM_DONE, OP_EM_IDX, OP_EM_FULL, OP_EM_NF, OP_EM_READ, OP_EM_PEND,
        OP_EM_RUN
    } dp_op_t;

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH, S_FIN, S_ERR_IDX, S_ERR_FULL, S_ERR_NF,
        S_INS_RD, S_INS_WR, S_INS_PUT,
        S_RM_RD, S_RM_WR, S_RM_END,
        S_RD_RD, S_RD_EM,
        S_FD_RD, S_FD_EV, S_FD_END,
        S_RV_RD, S_RV_EV, S_RV_END,
        S_DD_RD, S_DD_HOLD, S_DD_JRD, S_DD_JEV, S_DD_END,
        S_ST_RD, S_ST_HOLD, S_ST_JRD, S_ST_JEV, S_ST_END,
        S_PC_RD, S_PC_EV,
        S_REV_RA, S_REV_RB, S_REV_WA, S_REV_WB, S_REV_END,
        S_RN_RD0, S_RN_HOLD, S_RN_RD, S_RN_EV, S_RN_EM
    } ctl_state_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             idx_gt_len;
        logic             idx_ge_len;
        logic             full;
        logic             len_zero;
        logic             i_eq_idx;
        logic             i1_ge_len;
        logic             i_ge_len;
        logic             j_ge_len;
        logic             j_ge_w;
        logic             cap;
        logic             eq_a;
        logic             lo_ge_hi;
        logic             pend;
        logic             phase;
        logic             w_eq_len;
        logic             out_free;
        logic             fd_stall;
    } sle_stat_t;

endpackage

// ----- rtl/sle_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sle_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sle_ctrl.sv -----
`timescale 1ns / 1ps
// Command sequencer of the sequence list engine.
// Depends on sle_pkg; drives sle_dpath through one op code per cycle.
module sle_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sle_pkg::sle_stat_t stat,
    output sle_pkg::dp_op_t    op
);
    import sle_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NOP;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_CLEAR:
                    begin
                        op         = OP_CLEAR;
                        state_next = S_FIN;
                    end
                    CMD_INSERT:
                    begin
                        if (stat.idx_gt_len)
                        begin
                            state_next = S_ERR_IDX;
                        end
                        else if (stat.full)
                        begin
                            state_next = S_ERR_FULL;
                        end
                        else
                        begin
                            op         = OP_INS_INIT;
                            state_next = S_INS_RD;
                        end
                    end
                    CMD_REMOVE_AT:
                    begin
                        if (stat.idx_ge_len)
                        begin
                            state_next = S_ERR_IDX;
                        end
                        else
                        begin
                            op         = OP_RM_INIT;
                            state_next = S_RM_RD;
                        end
                    end
                    CMD_READ:
                    begin
                        if (stat.idx_ge_len)
                        begin
                            state_next = S_ERR_IDX;
                        end
                        else
                        begin
                            op         = OP_RM_INIT;
                            state_next = S_RD_RD;
                        end
                    end
                    CMD_FIND:
                    begin
                        op         = OP_SCAN_INIT;
                        state_next = S_FD_RD;
                    end
                    CMD_REMOVE_VAL:
                    begin
                        op         = OP_SCAN_INIT;
                        state_next = S_RV_RD;
                    end
                    CMD_DEDUPE:
                    begin
                        op         = OP_SCAN_INIT;
                        state_next = S_DD_RD;
                    end
                    CMD_REVERSE:
                    begin
                        if (stat.len_zero)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            op         = OP_REV_INIT;
                            state_next = S_REV_RA;
                        end
                    end
                    CMD_SORT, CMD_PARTITION:
                    begin
                        if (stat.len_zero)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            op         = OP_SCAN_INIT;
                            state_next = S_ST_RD;
                        end
                    end
                    CMD_RUN:
                    begin
                        if (stat.len_zero)
                        begin
                            state_next = S_ERR_NF;
                        end
                        else
                        begin
                            op         = OP_SCAN_INIT;
                            state_next = S_RN_RD0;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_FIN:
            begin
                op = OP_EM_DONE;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERR_IDX:
            begin
                op = OP_EM_IDX;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERR_FULL:
            begin
                op = OP_EM_FULL;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERR_NF:
            begin
                op = OP_EM_NF;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_INS_RD:
            begin
                if (stat.i_eq_idx)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    op         = OP_INS_RD;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                op         = OP_INS_WR;
                state_next = S_INS_RD;
            end
            S_INS_PUT:
            begin
                op         = OP_INS_PUT;
                state_next = S_FIN;
            end
            S_RM_RD:
            begin
                if (stat.i1_ge_len)
                begin
                    state_next = S_RM_END;
                end
                else
                begin
                    op         = OP_RM_RD;
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                op         = OP_RM_WR;
                state_next = S_RM_RD;
            end
            S_RM_END:
            begin
                op         = OP_RM_END;
                state_next = S_FIN;
            end
            S_RD_RD:
            begin
                op         = OP_RD_I;
                state_next = S_RD_EM;
            end
            S_RD_EM:
            begin
                op = OP_EM_READ;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FD_RD:
            begin
                if (stat.i_ge_len || stat.cap)
                begin
                    state_next = S_FD_END;
                end
                else
                begin
                    op         = OP_RD_I;
                    state_next = S_FD_EV;
                end
            end
            S_FD_EV:
            begin
                op = OP_FD_EV;
                if (!stat.fd_stall)
                begin
                    state_next = S_FD_RD;
                end
            end
            S_FD_END:
            begin
                op = stat.pend ? OP_EM_PEND : OP_EM_NF;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RV_RD:
            begin
                if (stat.i_ge_len)
                begin
                    state_next = S_RV_END;
                end
                else
                begin
                    op         = OP_RD_I;
                    state_next = S_RV_EV;
                end
            end
            S_RV_EV:
            begin
                op         = OP_RV_EV;
                state_next = S_RV_RD;
            end
            S_RV_END:
            begin
                if (stat.w_eq_len)
                begin
                    state_next = S_ERR_NF;
                end
                else
                begin
                    op         = OP_SET_LEN_W;
                    state_next = S_FIN;
                end
            end
            S_DD_RD:
            begin
                if (stat.i_ge_len)
                begin
                    state_next = S_DD_END;
                end
                else
                begin
                    op         = OP_RD_I;
                    state_next = S_DD_HOLD;
                end
            end
            S_DD_HOLD:
            begin
                op         = OP_DD_HOLD;
                state_next = S_DD_JRD;
            end
            S_DD_JRD:
            begin
                if (stat.j_ge_w)
                begin
                    op         = OP_DD_ADD;
                    state_next = S_DD_RD;
                end
                else
                begin
                    op         = OP_RD_J;
                    state_next = S_DD_JEV;
                end
            end
            S_DD_JEV:
            begin
                op         = OP_DD_JEV;
                state_next = stat.eq_a ? S_DD_RD : S_DD_JRD;
            end
            S_DD_END:
            begin
                op         = OP_SET_LEN_W;
                state_next = S_FIN;
            end
            S_ST_RD:
            begin
                if (stat.i1_ge_len)
                begin
                    state_next = S_ST_END;
                end
                else
                begin
                    op         = OP_RD_I;
                    state_next = S_ST_HOLD;
                end
            end
            S_ST_HOLD:
            begin
                op         = OP_ST_HOLD;
                state_next = S_ST_JRD;
            end
            S_ST_JRD:
            begin
                if (stat.j_ge_len)
                begin
                    op         = OP_ST_PUT;
                    state_next = S_ST_RD;
                end
                else
                begin
                    op         = OP_RD_J;
                    state_next = S_ST_JEV;
                end
            end
            S_ST_JEV:
            begin
                op         = OP_ST_JEV;
                state_next = S_ST_JRD;
            end
            S_ST_END:
            begin
                if (stat.cmd == CMD_PARTITION)
                begin
                    op         = OP_SCAN_INIT;
                    state_next = S_PC_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_PC_RD:
            begin
                if (stat.i_ge_len)
                begin
                    op         = OP_REV_INIT;
                    state_next = S_REV_RA;
                end
                else
                begin
                    op         = OP_RD_I;
                    state_next = S_PC_EV;
                end
            end
            S_PC_EV:
            begin
                op         = OP_PC_EV;
                state_next = S_PC_RD;
            end
            S_REV_RA:
            begin
                if (stat.lo_ge_hi)
                begin
                    state_next = S_REV_END;
                end
                else
                begin
                    op         = OP_REV_RA;
                    state_next = S_REV_RB;
                end
            end
            S_REV_RB:
            begin
                op         = OP_REV_RB;
                state_next = S_REV_WA;
            end
            S_REV_WA:
            begin
                op         = OP_REV_WA;
                state_next = S_REV_WB;
            end
            S_REV_WB:
            begin
                op         = OP_REV_WB;
                state_next = S_REV_RA;
            end
            S_REV_END:
            begin
                if (stat.cmd == CMD_PARTITION && !stat.phase)
                begin
                    op         = OP_REV_INIT2;
                    state_next = S_REV_RA;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_RN_RD0:
            begin
                op         = OP_RD_I;
                state_next = S_RN_HOLD;
            end
            S_RN_HOLD:
            begin
                op         = OP_RN_HOLD;
                state_next = S_RN_RD;
            end
            S_RN_RD:
            begin
                if (stat.i_ge_len)
                begin
                    op         = OP_RD_BST;
                    state_next = S_RN_EM;
                end
                else
                begin
                    op         = OP_RD_I;
                    state_next = S_RN_EV;
                end
            end
            S_RN_EV:
            begin
                op         = OP_RN_EV;
                state_next = S_RN_RD;
            end
            S_RN_EM:
            begin
                op = OP_EM_RUN;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sle_dpath.sv -----
`timescale 1ns / 1ps
// Datapath of the sequence list engine: list RAM, walk pointers and result register.
// Depends on sle_pkg and sle_ram; executes the op code from sle_ctrl.
module sle_dpath #(
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sle_pkg::dp_op_t                  op,
    output sle_pkg::sle_stat_t               stat,
    input  logic [sle_pkg::CMD_W-1:0]        command,
    input  logic [sle_pkg::IDX_W-1:0]        index,
    input  logic signed [sle_pkg::DATA_W-1:0] operand_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sle_pkg::STS_W-1:0]        status,
    output logic signed [sle_pkg::DATA_W-1:0] result_value,
    output logic [sle_pkg::POS_W-1:0]        position,
    output logic [sle_pkg::CNT_W-1:0]        count,
    output logic                             last
);
    import sle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > IDX_W) ? LW : IDX_W;

    // control state
    logic [LW-1:0] len_reg, len_next;
    logic          out_valid_reg, out_valid_next;
    logic          pend_reg, pend_next;
    logic          phase_reg, phase_next;

    // working registers
    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] a_reg, a_next;
    logic [LW-1:0]            i_reg, i_next;
    logic [LW-1:0]            j_reg, j_next;
    logic [LW-1:0]            w_reg, w_next;
    logic [LW-1:0]            lo_reg, lo_next;
    logic [LW-1:0]            hi_reg, hi_next;
    logic [LW-1:0]            p_reg, p_next;
    logic [LW-1:0]            pend_pos_reg, pend_pos_next;
    logic [LW-1:0]            best_reg, best_next;
    logic [LW-1:0]            bstart_reg, bstart_next;
    logic [LW-1:0]            cur_reg, cur_next;
    logic [LW-1:0]            cstart_reg, cstart_next;
    logic [CNT_W-1:0]         m_reg, m_next;

    // result register
    logic [STS_W-1:0]         sts_reg, sts_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     last_reg, last_next;

    // RAM port
    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_wa, ram_ra;
    logic [DATA_W-1:0]        ram_wd, ram_rdata;
    logic signed [DATA_W-1:0] rd;

    logic [LW:0]   i_inc;
    logic [LW-1:0] i_dec;
    logic [LW-1:0] len_dec;
    logic          out_free;
    logic          eq_val;
    logic          eq_a;
    logic [LW-1:0] run_cur;
    logic [LW-1:0] run_cst;

    sle_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_wa),
        .wdata(ram_wd),
        .re   (ram_re),
        .raddr(ram_ra),
        .rdata(ram_rdata)
    );

    assign rd       = ram_rdata;
    assign i_inc    = {1'b0, i_reg} + 1'b1;
    assign i_dec    = i_reg - 1'b1;
    assign len_dec  = len_reg - 1'b1;
    assign out_free = !out_valid_reg || out_ready;
    assign eq_val   = (rd == val_reg);
    assign eq_a     = (rd == a_reg);
    assign run_cur  = eq_a ? cur_reg + 1'b1 : LW'(1);
    assign run_cst  = eq_a ? cstart_reg : i_reg;

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.idx_gt_len = CW'(idx_reg) > CW'(len_reg);
        stat.idx_ge_len = CW'(idx_reg) >= CW'(len_reg);
        stat.full       = (len_reg == LW'(DEPTH));
        stat.len_zero   = (len_reg == '0);
        stat.i_eq_idx   = (CW'(i_reg) == CW'(idx_reg));
        stat.i1_ge_len  = (i_inc >= {1'b0, len_reg});
        stat.i_ge_len   = (i_reg >= len_reg);
        stat.j_ge_len   = (j_reg >= len_reg);
        stat.j_ge_w     = (j_reg >= w_reg);
        stat.cap        = (m_reg == CNT_W'(MAX_RESULTS));
        stat.eq_a       = eq_a;
        stat.lo_ge_hi   = (lo_reg >= hi_reg);
        stat.pend       = pend_reg;
        stat.phase      = phase_reg;
        stat.w_eq_len   = (w_reg == len_reg);
        stat.out_free   = out_free;
        stat.fd_stall   = eq_val && pend_reg && !out_free;
    end

    always_comb
    begin
        len_next       = len_reg;
        pend_next      = pend_reg;
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        a_next         = a_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        p_next         = p_reg;
        pend_pos_next  = pend_pos_reg;
        best_next      = best_reg;
        bstart_next    = bstart_reg;
        cur_next       = cur_reg;
        cstart_next    = cstart_reg;
        m_next         = m_reg;
        sts_next       = sts_reg;
        res_next       = res_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wa         = '0;
        ram_ra         = '0;
        ram_wd         = '0;

        case (op)
            OP_LOAD:
            begin
                cmd_next = command;
                idx_next = index;
                val_next = operand_value;
            end
            OP_CLEAR:
            begin
                len_next = '0;
            end
            OP_INS_INIT:
            begin
                i_next = len_reg;
            end
            OP_INS_RD:
            begin
                ram_re = 1'b1;
                ram_ra = i_dec[AW-1:0];
            end
            OP_INS_WR:
            begin
                ram_we = 1'b1;
                ram_wa = i_reg[AW-1:0];
                ram_wd = rd;
                i_next = i_dec;
            end
            OP_INS_PUT:
            begin
                ram_we   = 1'b1;
                ram_wa   = i_reg[AW-1:0];
                ram_wd   = val_reg;
                len_next = len_reg + 1'b1;
            end
            OP_RM_INIT:
            begin
                i_next = LW'(idx_reg);
            end
            OP_RM_RD:
            begin
                ram_re = 1'b1;
                ram_ra = i_inc[AW-1:0];
            end
            OP_RM_WR:
            begin
                ram_we = 1'b1;
                ram_wa = i_reg[AW-1:0];
                ram_wd = rd;
                i_next = i_inc[LW-1:0];
            end
            OP_RM_END:
            begin
                len_next = len_dec;
            end
            OP_SCAN_INIT:
            begin
                i_next    = '0;
                j_next    = '0;
                w_next    = '0;
                p_next    = '0;
                m_next    = '0;
                pend_next = 1'b0;
            end
            OP_RD_I:
            begin
                ram_re = 1'b1;
                ram_ra = i_reg[AW-1:0];
            end
            OP_RD_J:
            begin
                ram_re = 1'b1;
                ram_ra = j_reg[AW-1:0];
            end
            OP_FD_EV:
            begin
                // a match pushes out the previous one, which is then known not to be last
                if (!eq_val)
                begin
                    i_next = i_inc[LW-1:0];
                end
                else if (!pend_reg || out_free)
                begin
                    if (pend_reg)
                    begin
                        out_valid_next = 1'b1;
                        sts_next       = STS_OK;
                        res_next       = val_reg;
                        pos_next       = POS_W'(pend_pos_reg);
                        cnt_next       = CNT_W'(len_reg);
                        last_next      = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_pos_next = i_reg;
                    m_next        = m_reg + 1'b1;
                    i_next        = i_inc[LW-1:0];
                end
            end
            OP_RV_EV:
            begin
                if (!eq_val)
                begin
                    ram_we = 1'b1;
                    ram_wa = w_reg[AW-1:0];
                    ram_wd = rd;
                    w_next = w_reg + 1'b1;
                end
                i_next = i_inc[LW-1:0];
            end
            OP_SET_LEN_W:
            begin
                len_next = w_reg;
            end
            OP_DD_HOLD:
            begin
                a_next = rd;
                j_next = '0;
            end
            OP_DD_ADD:
            begin
                ram_we = 1'b1;
                ram_wa = w_reg[AW-1:0];
                ram_wd = a_reg;
                w_next = w_reg + 1'b1;
                i_next = i_inc[LW-1:0];
            end
            OP_DD_JEV:
            begin
                if (eq_a)
                begin
                    i_next = i_inc[LW-1:0];
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            OP_ST_HOLD:
            begin
                a_next = rd;
                j_next = i_inc[LW-1:0];
            end
            OP_ST_JEV:
            begin
                // hold the running maximum in a, drop the smaller one back at j
                if (a_reg < rd)
                begin
                    ram_we = 1'b1;
                    ram_wa = j_reg[AW-1:0];
                    ram_wd = a_reg;
                    a_next = rd;
                end
                j_next = j_reg + 1'b1;
            end
            OP_ST_PUT:
            begin
                ram_we = 1'b1;
                ram_wa = i_reg[AW-1:0];
                ram_wd = a_reg;
                i_next = i_inc[LW-1:0];
            end
            OP_PC_EV:
            begin
                if (rd >= val_reg)
                begin
                    p_next = p_reg + 1'b1;
                end
                i_next = i_inc[LW-1:0];
            end
            OP_REV_INIT:
            begin
                lo_next    = '0;
                hi_next    = len_dec;
                phase_next = 1'b0;
            end
            OP_REV_INIT2:
            begin
                lo_next    = len_reg - p_reg;
                hi_next    = len_dec;
                phase_next = 1'b1;
            end
            OP_REV_RA:
            begin
                ram_re = 1'b1;
                ram_ra = lo_reg[AW-1:0];
            end
            OP_REV_RB:
            begin
                a_next = rd;
                ram_re = 1'b1;
                ram_ra = hi_reg[AW-1:0];
            end
            OP_REV_WA:
            begin
                ram_we = 1'b1;
                ram_wa = lo_reg[AW-1:0];
                ram_wd = rd;
            end
            OP_REV_WB:
            begin
                ram_we  = 1'b1;
                ram_wa  = hi_reg[AW-1:0];
                ram_wd  = a_reg;
                lo_next = lo_reg + 1'b1;
                hi_next = hi_reg - 1'b1;
            end
            OP_RN_HOLD:
            begin
                a_next      = rd;
                i_next      = LW'(1);
                best_next   = LW'(1);
                bstart_next = '0;
                cur_next    = LW'(1);
                cstart_next = '0;
            end
            OP_RN_EV:
            begin
                cur_next    = run_cur;
                cstart_next = run_cst;
                if (run_cur > best_reg)
                begin
                    best_next   = run_cur;
                    bstart_next = run_cst;
                end
                a_next = rd;
                i_next = i_inc[LW-1:0];
            end
            OP_RD_BST:
            begin
                ram_re = 1'b1;
                ram_ra = bstart_reg[AW-1:0];
            end
            OP_EM_DONE, OP_EM_IDX, OP_EM_FULL, OP_EM_NF:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    res_next       = '0;
                    pos_next       = '0;
                    cnt_next       = CNT_W'(len_reg);
                    last_next      = 1'b1;
                    case (op)
                        OP_EM_IDX:  sts_next = STS_BAD_INDEX;
                        OP_EM_FULL: sts_next = STS_FULL;
                        OP_EM_NF:   sts_next = STS_NOT_FOUND;
                        default:    sts_next = STS_OK;
                    endcase
                end
            end
            OP_EM_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sts_next       = STS_OK;
                    res_next       = rd;
                    pos_next       = POS_W'(i_reg);
                    cnt_next       = CNT_W'(len_reg);
                    last_next      = 1'b1;
                end
            end
            OP_EM_PEND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sts_next       = STS_OK;
                    res_next       = val_reg;
                    pos_next       = POS_W'(pend_pos_reg);
                    cnt_next       = CNT_W'(len_reg);
                    last_next      = 1'b1;
                end
            end
            OP_EM_RUN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sts_next       = STS_OK;
                    res_next       = rd;
                    pos_next       = POS_W'(bstart_reg);
                    cnt_next       = CNT_W'(best_reg);
                    last_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        a_reg        <= a_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        w_reg        <= w_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        p_reg        <= p_next;
        pend_pos_reg <= pend_pos_next;
        best_reg     <= best_next;
        bstart_reg   <= bstart_next;
        cur_reg      <= cur_next;
        cstart_reg   <= cstart_next;
        m_reg        <= m_next;
        sts_reg      <= sts_next;
        res_reg      <= res_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        last_reg     <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = sts_reg;
    assign result_value = res_reg;
    assign position     = pos_reg;
    assign count        = cnt_reg;
    assign last         = last_reg;

endmodule

// ----- rtl/sequence_list_engine.sv -----
`timescale 1ns / 1ps
// Sequence list engine top level: a list of signed 16-bit values driven by commands.
// Depends on sle_pkg, sle_ctrl, sle_dpath (and sle_ram through the datapath).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: command, index,
//   operand_value. Output channel (out_valid/out_ready) carries result beats:
//   status, result_value, position, count, last. Every command yields one beat
//   except a find with matches, which yields one beat per match (up to 64),
//   last set on the final one.
//   Commands run one at a time; in_ready is high only while the sequencer is idle.
//   Run times grow with the list length and are set by the single read port of the
//   list RAM (registered read).
//   The result beat sits in an output register; the next command beat is taken
//   while it waits. If the receiver stalls, the sequencer holds in its emit step
//   until the register frees up; a find holds its scan between matches.
//   Reset empties the list at once (length zero); RAM contents are left as is
//   and are never read before being written.

module sequence_list_engine #(
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sle_pkg::CMD_W-1:0]         command,
    input  logic [sle_pkg::IDX_W-1:0]         index,
    input  logic signed [sle_pkg::DATA_W-1:0] operand_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sle_pkg::STS_W-1:0]         status,
    output logic signed [sle_pkg::DATA_W-1:0] result_value,
    output logic [sle_pkg::POS_W-1:0]         position,
    output logic [sle_pkg::CNT_W-1:0]         count,
    output logic                              last
);
    import sle_pkg::*;

    dp_op_t    op;
    sle_stat_t stat;

    // sequencer: one op per cycle, steered by datapath status
    sle_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stat    (stat),
        .op      (op)
    );

    // datapath: list RAM, walk pointers, result register
    sle_dpath #(
        .DEPTH(DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .stat         (stat),
        .command      (command),
        .index        (index),
        .operand_value(operand_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_value (result_value),
        .position     (position),
        .count        (count),
        .last         (last)
    );

endmodule
